// ===== design/bc1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_pkg
// Shared types, constants and color arithmetic for the BC1 block decoder.
// ----------------------------------------------------------------------------
package bc1_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;

  localparam int unsigned COL_W = 12;
  localparam int unsigned ROW_W = 13;
  localparam int unsigned DIM_W = 13;

  localparam logic [COL_W-1:0] COL_LIMIT = '1;
  localparam logic [ROW_W-1:0] ROW_LIMIT = '1;

  // floor(333 * s / 1000) == (s * BLEND_RECIP) >> BLEND_SHIFT for every s up to 765.
  localparam logic [18:0] BLEND_RECIP = 19'd349176;
  localparam int unsigned BLEND_SHIFT = 20;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    rgb_t             color_a;
    rgb_t             color_b;
    logic [31:0]      index_bits;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row_start;
  } bc1_block_t;

  typedef struct packed {
    logic [3:0][23:0] palette;
    logic [31:0]      index_bits;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row_start;
  } bc1_pal_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [23:0]      pixel_0;
    logic [23:0]      pixel_1;
    logic [23:0]      pixel_2;
    logic [23:0]      pixel_3;
    logic [3:0]       visible_mask;
    logic             last_row;
  } bc1_row_t;

  function automatic rgb_t widen565(input logic [15:0] c);
    logic [13:0] r;
    logic [13:0] g;
    logic [13:0] b;
    r = 14'(c[15:11]) * 14'd527 + 14'd23;
    g = 14'(c[10:5]) * 14'd259 + 14'd33;
    b = 14'(c[4:0]) * 14'd527 + 14'd23;
    return {r[13:6], g[13:6], b[13:6]};
  endfunction

  // Two-thirds of the heavy channel plus one third of the light one, as
  // floor((666 * heavy + 333 * light) / 1000).
  function automatic logic [7:0] blend_chan(input logic [7:0] heavy, input logic [7:0] light);
    logic [9:0]  s;
    logic [27:0] prod;
    s    = {1'b0, heavy, 1'b0} + 10'(light);
    prod = 28'(s) * 28'(BLEND_RECIP);
    return prod[27:BLEND_SHIFT];
  endfunction

  function automatic rgb_t blend_rgb(input rgb_t heavy, input rgb_t light);
    return {blend_chan(heavy[23:16], light[23:16]),
            blend_chan(heavy[15:8], light[15:8]),
            blend_chan(heavy[7:0], light[7:0])};
  endfunction

endpackage

// ===== design/bc1_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_if
// Channel interfaces for compressed blocks, decoded rows and configuration.
// ----------------------------------------------------------------------------
interface bc1_block_if;
  logic        valid;
  logic        ready;
  logic [15:0] endpoint_a;
  logic [15:0] endpoint_b;
  logic [31:0] index_bits;
  logic        first_block;

  modport source(output valid, endpoint_a, endpoint_b, index_bits, first_block,
                 input ready);
  modport sink(input valid, endpoint_a, endpoint_b, index_bits, first_block,
               output ready);
endinterface

interface bc1_row_if;
  logic        valid;
  logic        ready;
  logic [11:0] column;
  logic [12:0] row;
  logic [23:0] pixel_0;
  logic [23:0] pixel_1;
  logic [23:0] pixel_2;
  logic [23:0] pixel_3;
  logic [3:0]  visible_mask;
  logic        last_row;

  modport source(output valid, column, row, pixel_0, pixel_1, pixel_2, pixel_3,
                 visible_mask, last_row, input ready);
  modport sink(input valid, column, row, pixel_0, pixel_1, pixel_2, pixel_3,
               visible_mask, last_row, output ready);
endinterface

interface bc1_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [12:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== design/bc1_texture_block_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_texture_block_decoder
// BC1 four-color block decoder producing one RGB888 pixel row per item.
// ----------------------------------------------------------------------------
// Each accepted compressed block yields four row items, top row first, and the
// output register moves one row per cycle while the row side is not stalling.
// With the pipeline full, a new block is accepted at the edge that loads
// the last row of the block two ahead of it. After a block is accepted, the
// intake register loads at the accepting edge, then the palette register and
// the output register, which presents the first row. Image width and height
// are written through the configuration channel; the user must do so only
// while the block is idle, as the block itself does not enforce this; there
// is no start-up sweep.
module bc1_texture_block_decoder (
  input  logic          clk,
  input  logic          rst,
  bc1_block_if.sink     block_in,
  bc1_row_if.source     row_out,
  bc1_cfg_if.sink       cfg
);
  import bc1_pkg::*;

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             blk_valid;
  logic             blk_ready;
  bc1_block_t       blk;
  logic             pal_valid;
  logic             pal_ready;
  bc1_pal_t         pal;
  bc1_row_t         out_row;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(4096);
      image_height <= DIM_W'(4096);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  bc1_intake u_intake (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (block_in.valid),
    .in_ready    (block_in.ready),
    .endpoint_a  (block_in.endpoint_a),
    .endpoint_b  (block_in.endpoint_b),
    .index_bits  (block_in.index_bits),
    .first_block (block_in.first_block),
    .image_width (image_width),
    .blk_valid   (blk_valid),
    .blk_ready   (blk_ready),
    .blk         (blk)
  );

  bc1_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .pal_valid (pal_valid),
    .pal_ready (pal_ready),
    .pal       (pal)
  );

  bc1_row_seq u_row_seq (
    .clk          (clk),
    .rst          (rst),
    .pal_valid    (pal_valid),
    .pal_ready    (pal_ready),
    .pal          (pal),
    .image_width  (image_width),
    .image_height (image_height),
    .out_valid    (row_out.valid),
    .out_ready    (row_out.ready),
    .out_row      (out_row)
  );

  assign row_out.column       = out_row.column;
  assign row_out.row          = out_row.row;
  assign row_out.pixel_0      = out_row.pixel_0;
  assign row_out.pixel_1      = out_row.pixel_1;
  assign row_out.pixel_2      = out_row.pixel_2;
  assign row_out.pixel_3      = out_row.pixel_3;
  assign row_out.visible_mask = out_row.visible_mask;
  assign row_out.last_row     = out_row.last_row;

endmodule

// ===== design/bc1_intake.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_intake
// Input register: widens both endpoints and tracks the running block position.
// ----------------------------------------------------------------------------
module bc1_intake (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             endpoint_a,
  input  logic [15:0]             endpoint_b,
  input  logic [31:0]             index_bits,
  input  logic                    first_block,
  input  logic [12:0]             image_width,
  output logic                    blk_valid,
  input  logic                    blk_ready,
  output bc1_pkg::bc1_block_t     blk
);
  import bc1_pkg::*;

  logic [COL_W-1:0] col_start;
  logic [ROW_W-1:0] row_start;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [DIM_W-1:0] next_col;
  logic [14:0]      wrap_at;
  logic             wrap;
  logic [ROW_W:0]   row_sum;
  logic [ROW_W-1:0] row_adv;
  logic             accept;

  assign in_ready = !blk_valid || blk_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cur_col  = first_block ? '0 : col_start;
    cur_row  = first_block ? '0 : row_start;
    next_col = {1'b0, cur_col} + DIM_W'(4);
    wrap_at  = ({2'b00, image_width} > 15'(MAX_DIMENSION)) ? 15'(MAX_DIMENSION)
                                                          : {2'b00, image_width};
    wrap     = ({2'b00, next_col} >= wrap_at) || (next_col > {1'b0, COL_LIMIT});
    row_sum  = {1'b0, cur_row} + (ROW_W+1)'(4);
    row_adv  = (row_sum > {1'b0, ROW_LIMIT}) ? ROW_LIMIT : row_sum[ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      col_start <= '0;
      row_start <= '0;
    end else if (accept) begin
      blk_valid <= 1'b1;
      if (wrap) begin
        col_start <= '0;
        row_start <= row_adv;
      end else begin
        col_start <= next_col[COL_W-1:0];
        row_start <= cur_row;
      end
    end else if (blk_ready) begin
      blk_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk.color_a    <= widen565(endpoint_a);
      blk.color_b    <= widen565(endpoint_b);
      blk.index_bits <= index_bits;
      blk.column     <= cur_col;
      blk.row_start  <= cur_row;
    end
  end

endmodule

// ===== design/bc1_palette.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_palette
// Palette register: both endpoints and the two blended colors of a block.
// ----------------------------------------------------------------------------
module bc1_palette (
  input  logic                clk,
  input  logic                rst,
  input  logic                blk_valid,
  output logic                blk_ready,
  input  bc1_pkg::bc1_block_t blk,
  output logic                pal_valid,
  input  logic                pal_ready,
  output bc1_pkg::bc1_pal_t   pal
);
  import bc1_pkg::*;

  logic accept;

  assign blk_ready = !pal_valid || pal_ready;
  assign accept    = blk_valid && blk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pal_valid <= 1'b0;
    end else if (accept) begin
      pal_valid <= 1'b1;
    end else if (pal_ready) begin
      pal_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pal.palette[0] <= blk.color_a;
      pal.palette[1] <= blk.color_b;
      pal.palette[2] <= blend_rgb(blk.color_a, blk.color_b);
      pal.palette[3] <= blend_rgb(blk.color_b, blk.color_a);
      pal.index_bits <= blk.index_bits;
      pal.column     <= blk.column;
      pal.row_start  <= blk.row_start;
    end
  end

endmodule

// ===== design/bc1_row_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_row_seq
// Row sequencer: steps through the four rows of a block into the output register.
// ----------------------------------------------------------------------------
module bc1_row_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              pal_valid,
  output logic              pal_ready,
  input  bc1_pkg::bc1_pal_t pal,
  input  logic [12:0]       image_width,
  input  logic [12:0]       image_height,
  output logic              out_valid,
  input  logic              out_ready,
  output bc1_pkg::bc1_row_t out_row
);
  import bc1_pkg::*;

  logic [1:0]       cnt;
  logic             emit;
  logic [7:0]       sel;
  logic [ROW_W:0]   row_sum;
  logic [ROW_W-1:0] row_y;
  logic [3:0]       mask;
  bc1_row_t         row_next;

  assign emit      = pal_valid && (!out_valid || out_ready);
  assign pal_ready = emit && (cnt == 2'd3);

  always_comb begin
    sel     = pal.index_bits[{cnt, 3'b000} +: 8];
    row_sum = {1'b0, pal.row_start} + (ROW_W+1)'(cnt);
    row_y   = (row_sum > {1'b0, ROW_LIMIT}) ? ROW_LIMIT : row_sum[ROW_W-1:0];
    for (int k = 0; k < 4; k++) begin
      mask[k] = (({1'b0, pal.column} + DIM_W'(k)) < image_width) && (row_y < image_height);
    end
    row_next.column       = pal.column;
    row_next.row          = row_y;
    row_next.pixel_0      = pal.palette[sel[1:0]];
    row_next.pixel_1      = pal.palette[sel[3:2]];
    row_next.pixel_2      = pal.palette[sel[5:4]];
    row_next.pixel_3      = pal.palette[sel[7:6]];
    row_next.visible_mask = mask;
    row_next.last_row     = (cnt == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        cnt       <= cnt + 2'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_row <= row_next;
    end
  end

endmodule

// ===== design/bc1_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc1_checker
// Port-level checks on the decoded row stream, bound to the top level.
// ----------------------------------------------------------------------------
module bc1_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_column,
  input logic [12:0] out_row,
  input logic [23:0] out_pixel_0,
  input logic [23:0] out_pixel_1,
  input logic [23:0] out_pixel_2,
  input logic [23:0] out_pixel_3,
  input logic [3:0]  out_mask,
  input logic        out_last
);

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("row item valid right after reset");

  // A stalled row item keeps its payload.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_column) && $stable(out_row) && $stable(out_pixel_0) &&
       $stable(out_pixel_1) && $stable(out_pixel_2) && $stable(out_pixel_3) &&
       $stable(out_mask) && $stable(out_last)))
    else $error("stalled row item changed");

  // Rows inside a block follow one another with no gap and the same column.
  a_row_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && out_column == $past(out_column) &&
       (out_row == 13'($past(out_row) + 13'd1) || out_row == 13'h1FFF)))
    else $error("row sequence inside a block broken");

  // Visible pixels always form a run starting at the leftmost one.
  a_mask_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_mask == 4'b0000 || out_mask == 4'b0001 || out_mask == 4'b0011 ||
                   out_mask == 4'b0111 || out_mask == 4'b1111))
    else $error("visibility mask not a run from the left");

endmodule

bind bc1_texture_block_decoder bc1_checker u_bc1_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (row_out.valid),
  .out_ready   (row_out.ready),
  .out_column  (row_out.column),
  .out_row     (row_out.row),
  .out_pixel_0 (row_out.pixel_0),
  .out_pixel_1 (row_out.pixel_1),
  .out_pixel_2 (row_out.pixel_2),
  .out_pixel_3 (row_out.pixel_3),
  .out_mask    (row_out.visible_mask),
  .out_last    (row_out.last_row)
);

// ===== tb/sv/tb_bc1_texture_block_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bc1_texture_block_decoder
// Self-checking testbench for the BC1 block decoder. Blocks are queued by the
// sequence below and offered by a clocked driver; each accepted block is run
// through a behavioral decoder that queues its four expected pixel rows. A
// clocked monitor takes rows with random back-pressure and compares them field
// by field. Phases cover reset geometry, wrapping, and zero and oversized
// image sizes.
// ----------------------------------------------------------------------------
module tb_bc1_texture_block_decoder;
  import bc1_pkg::*;

  localparam int unsigned ROW_SAT      = 8191;
  localparam int unsigned COL_MAX      = 4095;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PRINT_CAP    = 50;

  typedef struct packed {
    logic [15:0] color_a565;
    logic [15:0] color_b565;
    logic [31:0] idx;
    logic        restart;
  } block_item_t;

  typedef struct packed {
    cfg_reg_t    sel;
    logic [12:0] value;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst;

  bc1_block_if blk();
  bc1_row_if   rows();
  bc1_cfg_if   cfg_ch();

  bc1_texture_block_decoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .block_in (blk),
    .row_out  (rows),
    .cfg      (cfg_ch)
  );

  always #1 clk = ~clk;

  block_item_t pending_blocks[$];
  reg_write_t  reg_writes[$];
  bc1_row_t    expected_rows[$];

  // Decoder state and geometry as the block should hold them.
  int unsigned width_cfg;
  int unsigned height_cfg;
  int unsigned block_col;
  int unsigned block_row;

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles;
  int unsigned send_gap;
  int unsigned sink_stall;
  int unsigned hold_left;
  int unsigned hold_requests = 0;
  int unsigned hold_grants = 0;
  bit          src_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;
  block_item_t drv_item;
  reg_write_t  drv_write;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [23:0] expand565(input logic [15:0] c);
    int unsigned r;
    int unsigned g;
    int unsigned b;
    r = (int'(c[15:11]) * 527 + 23) >> 6;
    g = (int'(c[10:5]) * 259 + 33) >> 6;
    b = (int'(c[4:0]) * 527 + 23) >> 6;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [23:0] weighted_mix(input logic [23:0] a, input logic [23:0] b,
                                                input int unsigned wa, input int unsigned wb);
    logic [23:0] out;
    int unsigned v;
    for (int s = 0; s < 24; s += 8) begin
      v = (wa * a[s +: 8] + wb * b[s +: 8]) / 1000;
      out[s +: 8] = v[7:0];
    end
    return out;
  endfunction

  task automatic decode_block(input logic [15:0] ea, input logic [15:0] eb,
                              input logic [31:0] idx, input logic restart);
    logic [3:0][23:0] pal;
    logic [3:0][23:0] px;
    logic [7:0]       sel;
    bc1_row_t         r;
    int unsigned      y;
    int unsigned      wrap_at;
    int unsigned      next_col;
    if (restart) begin
      block_col = 0;
      block_row = 0;
    end
    pal[0] = expand565(ea);
    pal[1] = expand565(eb);
    pal[2] = weighted_mix(pal[0], pal[1], 666, 333);
    pal[3] = weighted_mix(pal[0], pal[1], 333, 666);
    for (int i = 0; i < 4; i++) begin
      sel = idx[8*i +: 8];
      y = block_row + i;
      if (y > ROW_SAT) y = ROW_SAT;
      for (int k = 0; k < 4; k++) begin
        px[k] = pal[sel[2*k +: 2]];
        r.visible_mask[k] = (block_col + k < width_cfg) && (y < height_cfg);
      end
      r.column   = block_col[11:0];
      r.row      = y[12:0];
      r.pixel_0  = px[0];
      r.pixel_1  = px[1];
      r.pixel_2  = px[2];
      r.pixel_3  = px[3];
      r.last_row = (i == 3);
      expected_rows.push_back(r);
    end
    // The wrap point never goes past the largest supported image.
    wrap_at = (width_cfg > MAX_DIMENSION) ? MAX_DIMENSION : width_cfg;
    next_col = block_col + 4;
    if (next_col >= wrap_at || next_col > COL_MAX) begin
      block_col = 0;
      block_row = block_row + 4;
      if (block_row > ROW_SAT) block_row = ROW_SAT;
    end else begin
      block_col = next_col;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t: row item mismatch on %s, got 0x%0h, expected 0x%0h",
               $time, what, got, want);
    end
  endtask

  task automatic check_row();
    bc1_row_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch("unexpected row item", {rows.row, 7'd0, rows.column}, 32'd0);
      return;
    end
    want = expected_rows.pop_front();
    if (rows.column !== want.column) report_mismatch("column", rows.column, want.column);
    if (rows.row !== want.row) report_mismatch("row", rows.row, want.row);
    if (rows.pixel_0 !== want.pixel_0) report_mismatch("pixel_0", rows.pixel_0, want.pixel_0);
    if (rows.pixel_1 !== want.pixel_1) report_mismatch("pixel_1", rows.pixel_1, want.pixel_1);
    if (rows.pixel_2 !== want.pixel_2) report_mismatch("pixel_2", rows.pixel_2, want.pixel_2);
    if (rows.pixel_3 !== want.pixel_3) report_mismatch("pixel_3", rows.pixel_3, want.pixel_3);
    if (rows.visible_mask !== want.visible_mask) begin
      report_mismatch("visible_mask", rows.visible_mask, want.visible_mask);
    end
    if (rows.last_row !== want.last_row) report_mismatch("last_row", rows.last_row, want.last_row);
  endtask

  // Block driver.
  always @(posedge clk) begin
    if (rst) begin
      blk.valid <= 1'b0;
      send_gap  <= 0;
      block_col = 0;
      block_row = 0;
    end else begin
      if (blk.valid && blk.ready) begin
        decode_block(blk.endpoint_a, blk.endpoint_b, blk.index_bits, blk.first_block);
      end
      if (!blk.valid || blk.ready) begin
        if (send_gap != 0) begin
          blk.valid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_blocks.size() != 0) begin
          drv_item = pending_blocks.pop_front();
          blk.valid       <= 1'b1;
          blk.endpoint_a  <= drv_item.color_a565;
          blk.endpoint_b  <= drv_item.color_b565;
          blk.index_bits  <= drv_item.idx;
          blk.first_block <= drv_item.restart;
          send_gap <= (src_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        end else begin
          blk.valid <= 1'b0;
        end
      end
    end
  end

  // Row monitor with back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      rows.ready <= 1'b0;
      sink_stall <= 0;
      hold_left  <= 0;
    end else begin
      if (rows.valid && rows.ready) check_row();
      if (hold_grants != hold_requests) begin
        hold_grants = hold_requests;
        hold_left  <= HOLD_CYCLES;
        rows.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        rows.ready <= 1'b0;
      end else if (sink_stall != 0) begin
        sink_stall <= sink_stall - 1;
        rows.ready <= 1'b0;
      end else begin
        rows.ready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 3) == 0) sink_stall <= pick_gap();
      end
    end
  end

  // Register write driver.
  always @(posedge clk) begin
    if (rst) begin
      cfg_ch.valid <= 1'b0;
      width_cfg  = MAX_DIMENSION;
      height_cfg = MAX_DIMENSION;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_IMAGE_WIDTH:  width_cfg = cfg_ch.data;
          REG_IMAGE_HEIGHT: height_cfg = cfg_ch.data;
          default: ;
        endcase
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (reg_writes.size() != 0) begin
          drv_write = reg_writes.pop_front();
          cfg_ch.valid <= 1'b1;
          cfg_ch.index <= drv_write.sel;
          cfg_ch.data  <= drv_write.value;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Watchdog: nothing moving on any channel for too long means a hang.
  always @(posedge clk) begin
    if (rst || (blk.valid && blk.ready) || (rows.valid && rows.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_block(input logic [15:0] ea, input logic [15:0] eb,
                             input logic [31:0] idx, input logic restart);
    pending_blocks.push_back('{color_a565: ea, color_b565: eb, idx: idx, restart: restart});
  endtask

  task automatic queue_random_blocks(input int unsigned count, input int unsigned restart_pct,
                                     input bit restart_first);
    logic [15:0] ea;
    logic [15:0] eb;
    for (int unsigned n = 0; n < count; n++) begin
      ea = $urandom_range(0, 65535);
      eb = $urandom_range(0, 65535);
      // Now and then pin an endpoint to a corner of the color space.
      case ($urandom_range(0, 9))
        0: ea = 16'h0000;
        1: ea = 16'hFFFF;
        2: eb = 16'h0000;
        3: eb = 16'hFFFF;
        default: ;
      endcase
      queue_block(ea, eb, $urandom(),
                  (restart_first && n == 0) || ($urandom_range(0, 99) < restart_pct));
    end
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [12:0] value);
    reg_writes.push_back('{sel: sel, value: value});
  endtask

  // Both writes land before any further block is queued.
  task automatic set_geometry(input logic [12:0] w, input logic [12:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    do begin
      @(negedge clk);
    end while (reg_writes.size() != 0 || cfg_ch.valid);
  endtask

  // Returns on a falling edge once nothing is queued, offered or outstanding.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_blocks.size() != 0 || blk.valid || expected_rows.size() != 0 ||
               reg_writes.size() != 0 || cfg_ch.valid);
  endtask

  initial begin
    rst               = 1'b1;
    blk.valid         = 1'b0;
    blk.endpoint_a    = '0;
    blk.endpoint_b    = '0;
    blk.index_bits    = '0;
    blk.first_block   = 1'b0;
    rows.ready        = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_IMAGE_WIDTH;
    cfg_ch.data       = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Geometry straight out of reset: color corners and every palette entry.
    queue_block(16'h0000, 16'h0000, 32'h0000_0000, 1'b1);
    queue_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_block(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 1'b0);
    queue_block(16'h0000, 16'hFFFF, 32'h1B1B_1B1B, 1'b0);
    queue_block(16'hF800, 16'h07E0, 32'h5555_5555, 1'b0);
    queue_block(16'h001F, 16'hF81F, 32'hAAAA_AAAA, 1'b0);
    queue_block(16'h7BEF, 16'h8410, 32'h0F0F_F0F0, 1'b1);
    queue_block(16'h1234, 16'hABCD, 32'h7654_3210, 1'b0);
    wait_idle();

    // A narrow image: the third block straddles the right edge, the fourth
    // wraps to the next block row, which straddles the bottom edge.
    set_geometry(13'd10, 13'd6);
    queue_random_blocks(5, 0, 1'b1);
    wait_idle();

    // Zero width and zero height: nothing visible and every block wraps.
    set_geometry(13'd0, 13'd0);
    queue_random_blocks(3, 0, 1'b1);
    wait_idle();

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    set_geometry(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
    queue_random_blocks(20, 10, 1'b1);
    wait_idle();

    // Smallest legal image, run back to back.
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_geometry(13'd1, 13'd1);
    queue_random_blocks(10, 10, 1'b0);
    wait_idle();

    // Hold the row side off while blocks keep coming, so the input backs up.
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    set_geometry(13'd40, 13'd30);
    queue_random_blocks(25, 5, 1'b1);
    hold_requests++;
    wait_idle();

    // Oversized registers: the wrap point clamps, and every pixel stays visible.
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_geometry(13'd8191, 13'd8191);
    queue_random_blocks(6, 0, 1'b1);
    wait_idle();

    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    set_geometry(13'd4096, 13'd4096);
    queue_random_blocks(15, 10, 1'b0);
    wait_idle();

    set_geometry(13'd13, 13'($urandom_range(1, 4096)));
    queue_random_blocks(20, 10, 1'b1);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bc1_pkg.sv
design/bc1_if.sv
design/bc1_intake.sv
design/bc1_palette.sv
design/bc1_row_seq.sv
design/bc1_texture_block_decoder.sv
design/bc1_checker.sv
tb/sv/tb_bc1_texture_block_decoder.sv
